// ----- hw/rtl/lrukv_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by lrukv_cell and lru_key_value_cache.
package lrukv_pkg;

  localparam logic        ACT_GET    = 1'b0;
  localparam logic        ACT_PUT    = 1'b1;
  localparam logic [4:0]  CAP_RESET  = 5'd16;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               action;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;
  } lrukv_in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
  } lrukv_out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] data;
  } lrukv_entry_t;

  typedef struct packed {
    logic        cmp_en;
    logic        upd_en;
    logic        use_match;
    logic [31:0] key;
  } lrukv_ctl_t;

endpackage

// ----- hw/rtl/lru_key_value_cache.sv -----
// Top level of the LRU key/value cache: control, occupancy and the cell row.
// Depends on lrukv_pkg and lrukv_cell.
//
// Fully associative store of up to ENTRIES key/value pairs kept in recency
// order along a row of cells, cell 0 most recent. Each request passes through
// the states S_IDLE, in which it is accepted and captured, S_CMP, in which
// every cell compares its key in parallel, and S_UPD, in which the row
// shifts by a position up to the hit (or up to the fill/eviction point) and
// the new entry enters cell 0. The result is registered at the end of S_UPD
// and the next request is accepted only once the block is back in S_IDLE;
// one request is never overlapped with another. A new request is taken
// while the previous result waits in the output register; its update cycle
// stretches until that result is accepted. The shift decision ripples along
// the row, which sets the update cycle's length. Capacity is written through
// the cfg port while idle; zero acts as one and values above ENTRIES act as
// ENTRIES.
module lru_key_value_cache import lrukv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lrukv_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output lrukv_out_t out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > 5) ? OW : 5;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  state_t       state_r;
  lrukv_in_t    req_r;
  lrukv_out_t   out_r;
  logic         out_valid_r;
  logic [4:0]   cap_r;
  logic [OW-1:0] occ_r;

  lrukv_ctl_t   ctl;
  lrukv_entry_t ent   [ENTRIES];
  lrukv_entry_t lft   [ENTRIES];
  logic         shf   [ENTRIES+1];
  logic [ENTRIES-1:0] match;

  logic          hit;
  logic [31:0]   hit_data;
  logic [CW-1:0] cap_x;
  logic [CW-1:0] eff_cap;
  logic [CW-1:0] occ_x;
  logic          has_room;
  logic          is_put;
  logic          upd_go;
  logic [IW-1:0] limit;
  lrukv_entry_t  new_ent;
  lrukv_out_t    rsp;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_put   = (req_r.action == ACT_PUT);
  assign upd_go   = (state_r == S_UPD) && (!out_valid_r || out_ready);
  assign cap_x    = CW'(cap_r);
  assign occ_x    = CW'(occ_r);
  assign eff_cap  = (cap_x == '0) ? CW'(1) :
                    (cap_x > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_x;
  assign has_room = (occ_x < eff_cap);

  always_comb begin
    hit      = 1'b0;
    hit_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit      = hit | match[i];
      hit_data = hit_data | (ent[i].data & {32{match[i]}});
    end
  end

  always_comb begin
    if (has_room) begin
      limit = IW'(occ_r);
    end else begin
      limit = IW'(occ_r - OW'(1));
    end
  end

  assign ctl.cmp_en    = (state_r == S_CMP);
  assign ctl.upd_en    = upd_go && (hit || is_put);
  assign ctl.use_match = hit;
  assign ctl.key       = req_r.lookup_key;

  assign new_ent.valid = 1'b1;
  assign new_ent.key   = req_r.lookup_key;
  assign new_ent.data  = is_put ? req_r.write_value : hit_data;

  assign rsp.found      = hit;
  assign rsp.read_value = is_put ? 32'sd0 : (hit ? hit_data : MISS_VALUE);
  assign rsp.evicted    = is_put && !hit && !has_room;

  assign shf[ENTRIES] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign lft[g] = new_ent;
    end else begin : g_body
      assign lft[g] = ent[g-1];
    end
    lrukv_cell #(.IW(IW), .INDEX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .limit     (limit),
      .left_in   (lft[g]),
      .shift_in  (shf[g+1]),
      .shift_out (shf[g]),
      .match     (match[g]),
      .entry     (ent[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (is_put && !hit && has_room) begin
              occ_r <= occ_r + OW'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (upd_go) begin
      out_r <= rsp;
    end
  end

endmodule

// ----- hw/rtl/lrukv_cell.sv -----
// One position of the recency chain: holds one entry and its key match flag.
// Depends on lrukv_pkg; instantiated in a row by lru_key_value_cache.
module lrukv_cell import lrukv_pkg::*; #(
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lrukv_ctl_t    ctl,
  input  logic [IW-1:0] limit,
  input  lrukv_entry_t  left_in,
  input  logic          shift_in,
  output logic          shift_out,
  output logic          match,
  output lrukv_entry_t  entry
);

  logic        valid_r;
  logic [31:0] key_r;
  logic [31:0] data_r;
  logic        match_r;
  logic        stop;

  assign stop      = ctl.use_match ? match_r : (limit == IW'(INDEX));
  assign shift_out = stop | shift_in;
  assign match     = match_r;
  assign entry     = '{valid: valid_r, key: key_r, data: data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        match_r <= valid_r && (key_r == ctl.key);
      end
      if (ctl.upd_en && shift_out) begin
        valid_r <= left_in.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd_en && shift_out) begin
      key_r  <= left_in.key;
      data_r <= left_in.data;
    end
  end

endmodule
